/* sv/tcw_pkg.sv */
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int OPCODE_W = 2;
  localparam int CHAR_W = 8;
  localparam int RD_ADDR_W = 11;
  localparam int OUT_COL_W = 7;
  localparam int OUT_ROW_W = 5;
  localparam int OUT_LIN_W = 11;
  localparam int CELL_W = 16;

  localparam logic [OPCODE_W-1:0] OP_PUT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_READ = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_NOP = 2'd3;

  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_RETURN = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_BLANK = 8'h20;
  localparam logic [CHAR_W-1:0] RESET_ATTRIBUTE = 8'h07;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCROLL,
    ST_CLEAR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [CHAR_W-1:0] char_code;
    logic [RD_ADDR_W-1:0] read_address;
  } req_t;

  typedef struct packed {
    logic scrolled;
    logic [CELL_W-1:0] cell_data;
    logic [OUT_LIN_W-1:0] cursor_linear;
    logic [OUT_ROW_W-1:0] cursor_row;
    logic [OUT_COL_W-1:0] cursor_column;
  } res_t;

endpackage

/* sv/tcw_engine.sv */
`timescale 1ns / 1ps

module tcw_engine
  import tcw_pkg::*;
#(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  input  logic [CHAR_W-1:0] attr,
  output logic        res_valid,
  input  logic        res_ready,
  output res_t        res
);

  localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int COL_W = $clog2(SCREEN_COLUMNS);
  localparam int ROW_W = $clog2(SCREEN_ROWS);
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int EXT_W = (ADDR_W > RD_ADDR_W) ? ADDR_W : RD_ADDR_W;

  state_t state, state_next;

  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CELL_W-1:0] rd_data;

  req_t              op;
  logic [ADDR_W-1:0] sweep;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [ADDR_W-1:0] lin;
  logic [CELL_W-1:0] read_cell;
  logic              scrolled;

  logic              copy_valid;
  logic [ADDR_W-1:0] copy_addr;
  logic              copy_blank;

  logic              is_put;
  logic              is_newline;
  logic              is_return;
  logic              col_end;
  logic              row_end;
  logic              need_scroll;
  logic              sweep_last;
  logic              sweep_tail;
  logic [ADDR_W:0]   scroll_src;
  logic [EXT_W:0]    addr_ext;
  logic              addr_ok;
  logic [ADDR_W-1:0] newline_lin;

  assign is_put     = (op.opcode == OP_PUT);
  assign is_newline = (op.char_code == CHAR_NEWLINE);
  assign is_return  = (op.char_code == CHAR_RETURN);
  assign col_end    = (col == COL_W'(SCREEN_COLUMNS - 1));
  assign row_end    = (row == ROW_W'(SCREEN_ROWS - 1));
  // The row advances on a newline or on a wrap at the end of the row.
  assign need_scroll = is_put && row_end && (is_newline || (!is_return && col_end));
  assign sweep_last = (sweep == ADDR_W'(CELL_COUNT - 1));
  assign sweep_tail = (sweep >= ADDR_W'(CELL_COUNT - SCREEN_COLUMNS));
  assign scroll_src = {1'b0, sweep} + (ADDR_W + 1)'(SCREEN_COLUMNS);
  assign addr_ext   = (EXT_W + 1)'(op.read_address);
  assign addr_ok    = (addr_ext < (EXT_W + 1)'(CELL_COUNT));
  assign newline_lin = lin - ADDR_W'(col) + ADDR_W'(SCREEN_COLUMNS);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT:   if (sweep_last) state_next = ST_IDLE;
      ST_IDLE:   if (req_valid) state_next = ST_EXEC;
      ST_EXEC: begin
        if (op.opcode == OP_READ) begin
          state_next = ST_READ;
        end else if (op.opcode == OP_CLEAR) begin
          state_next = ST_CLEAR;
        end else if (need_scroll) begin
          state_next = ST_SCROLL;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_READ:   state_next = ST_DONE;
      ST_SCROLL: if (sweep_last) state_next = ST_DONE;
      ST_CLEAR:  if (sweep_last) state_next = ST_DONE;
      ST_DONE:   if (res_ready) state_next = ST_IDLE;
      default:   state_next = ST_INIT;
    endcase
  end

  always_comb begin
    req_ready = (state == ST_IDLE);
    res_valid = (state == ST_DONE);
    mem_re    = 1'b0;
    mem_raddr = sweep;
    mem_we    = 1'b0;
    mem_waddr = sweep;
    mem_wdata = {attr, CHAR_BLANK};
    // The trailing copy write of a scroll owns the write port whenever it is live.
    if (copy_valid) begin
      mem_we    = 1'b1;
      mem_waddr = copy_addr;
      mem_wdata = copy_blank ? {attr, CHAR_BLANK} : rd_data;
    end
    unique case (state)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = {RESET_ATTRIBUTE, CHAR_BLANK};
      end
      ST_CLEAR: mem_we = 1'b1;
      ST_EXEC: begin
        if (is_put && !is_newline && !is_return) begin
          mem_we    = 1'b1;
          mem_waddr = lin;
          mem_wdata = {attr, op.char_code};
        end
        if (op.opcode == OP_READ) begin
          mem_re    = addr_ok;
          mem_raddr = addr_ext[ADDR_W-1:0];
        end
      end
      ST_SCROLL: begin
        mem_re    = !sweep_tail;
        mem_raddr = scroll_src[ADDR_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      sweep      <= '0;
      col        <= '0;
      row        <= '0;
      lin        <= '0;
      copy_valid <= 1'b0;
    end else begin
      state      <= state_next;
      copy_valid <= (state == ST_SCROLL);
      if (state == ST_INIT || state == ST_CLEAR || state == ST_SCROLL) begin
        sweep <= sweep_last ? '0 : sweep + 1'b1;
      end
      if (state == ST_EXEC) begin
        if (op.opcode == OP_CLEAR) begin
          col <= '0;
          row <= '0;
          lin <= '0;
        end else if (is_put) begin
          if (is_newline || is_return || col_end) begin
            col <= '0;
            if (is_return) begin
              lin <= lin - ADDR_W'(col);
            end else if (row_end) begin
              lin <= ADDR_W'(CELL_COUNT - SCREEN_COLUMNS);
            end else begin
              row <= row + 1'b1;
              lin <= newline_lin;
            end
          end else begin
            col <= col + 1'b1;
            lin <= lin + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    copy_addr  <= sweep;
    copy_blank <= sweep_tail;
    if (req_valid && req_ready) begin
      op        <= req;
      scrolled  <= 1'b0;
      read_cell <= '0;
    end
    if (state == ST_EXEC) begin
      scrolled <= need_scroll;
    end
    if (state == ST_READ) begin
      read_cell <= addr_ok ? rd_data : '0;
    end
  end

  assign res.scrolled      = scrolled;
  assign res.cell_data     = read_cell;
  assign res.cursor_linear = OUT_LIN_W'(lin);
  assign res.cursor_row    = OUT_ROW_W'(row);
  assign res.cursor_column = OUT_COL_W'(col);

endmodule

/* sv/text_console_writer_top.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// s_*       request    s_tvalid/s_tready  tuser: opcode; tdata: char_code, read_address
// m_*       result     m_tvalid/m_tready  tdata: cursor, cell_data, scrolled
// attribute config     text_attribute_we  text_attribute, taken on any write edge
//
// After reset a clearing pass writes every cell once, with s_tready low. A put,
// carriage return or newline without scroll passes through the execute and done
// states to the result register; a cell read adds a read state between them.
// A scroll or a clear screen sweeps the cell memory once through its single
// write port. The engine works on one request at a time; a result stalled on m_tready
// holds the engine in its last state.

module text_console_writer_top
  import tcw_pkg::*;
#(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,          // char_code[7:0], read_address[18:8], zero pad
  input  logic [1:0]  s_tuser,          // opcode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,          // cursor_column[6:0], cursor_row[11:7],
                                        // cursor_linear[22:12], cell_data[38:23],
                                        // scrolled[39]
  input  logic        text_attribute_we,
  input  logic [7:0]  text_attribute
);

  logic [CHAR_W-1:0] attr;
  req_t              req;
  res_t              res;
  logic              res_valid;
  logic              res_ready;

  assign req.opcode       = s_tuser;
  assign req.char_code    = s_tdata[7:0];
  assign req.read_address = s_tdata[18:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= RESET_ATTRIBUTE;
    end else if (text_attribute_we) begin
      attr <= text_attribute;
    end
  end

  tcw_engine #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS(SCREEN_ROWS)
  ) u_engine (
    .clk(clk),
    .rst(rst),
    .req_valid(s_tvalid),
    .req_ready(s_tready),
    .req(req),
    .attr(attr),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= res;
    end
  end

endmodule

/* sv/tcw_checker.sv */
`timescale 1ns / 1ps

module tcw_checker #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS = 25
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  logic [6:0]  col;
  logic [4:0]  row;
  logic [10:0] lin;

  assign col = m_tdata[6:0];
  assign row = m_tdata[11:7];
  assign lin = m_tdata[22:12];

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // The clearing pass keeps requests out right after reset.
  a_init: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("request taken during clearing pass");

  // A scroll always leaves the cursor at the start of the last row.
  a_scroll: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[39] |-> row == 5'(SCREEN_ROWS - 1) && col == 7'd0)
    else $error("scroll left the cursor off the last row");

  if (SCREEN_COLUMNS <= 128 && SCREEN_ROWS <= 32) begin : g_lin
    a_linear: assert property (@(posedge clk) disable iff (rst)
      m_tvalid |-> lin == 11'(32'(row) * SCREEN_COLUMNS + 32'(col)))
      else $error("cursor location does not match row and column");
  end

endmodule

bind text_console_writer_top tcw_checker #(
  .SCREEN_COLUMNS(SCREEN_COLUMNS),
  .SCREEN_ROWS(SCREEN_ROWS)
) u_tcw_checker (.*);

/* tb/sv/text_console_writer_checker.sv */
`timescale 1ns / 1ps

module text_console_writer_checker
  import tcw_pkg::*;
#(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        text_attribute_we,
  input  logic [7:0]  text_attribute,
  output int          mismatches,
  output int          outstanding
);

  localparam int CELLS = SCREEN_COLUMNS * SCREEN_ROWS;

  logic [CELL_W-1:0] screen [CELLS];
  int unsigned       cur_col;
  int unsigned       cur_row;
  logic [7:0]        attr;
  res_t              cursor_reports_q [$];
  int                fail_count = 0;

  task blank_cells(input int first, input int count);
    for (int i = first; i < first + count; i++) begin
      screen[i] = {attr, CHAR_BLANK};
    end
  endtask

  // Moves to the next row; past the bottom the whole screen rolls up one row.
  task feed_line(output logic rolled);
    cur_row++;
    rolled = 1'b0;
    if (cur_row >= SCREEN_ROWS) begin
      for (int i = 0; i < CELLS - SCREEN_COLUMNS; i++) begin
        screen[i] = screen[i + SCREEN_COLUMNS];
      end
      blank_cells(CELLS - SCREEN_COLUMNS, SCREEN_COLUMNS);
      cur_row = SCREEN_ROWS - 1;
      rolled = 1'b1;
    end
  endtask

  task console_apply(input logic [1:0] op, input logic [7:0] ch,
                     input logic [10:0] addr, output res_t rep);
    logic [CELL_W-1:0] read_cell;
    logic              rolled;
    int unsigned       linear;
    read_cell = '0;
    rolled = 1'b0;
    case (op)
      OP_PUT: begin
        if (ch == CHAR_NEWLINE) begin
          cur_col = 0;
          feed_line(rolled);
        end else if (ch == CHAR_RETURN) begin
          cur_col = 0;
        end else begin
          screen[cur_row * SCREEN_COLUMNS + cur_col] = {attr, ch};
          cur_col++;
          if (cur_col >= SCREEN_COLUMNS) begin
            cur_col = 0;
            feed_line(rolled);
          end
        end
      end
      OP_READ: begin
        if (addr < CELLS) read_cell = screen[addr];
      end
      OP_CLEAR: begin
        blank_cells(0, CELLS);
        cur_col = 0;
        cur_row = 0;
      end
      default: begin
      end
    endcase
    linear = cur_row * SCREEN_COLUMNS + cur_col;
    rep.cursor_column = cur_col[OUT_COL_W-1:0];
    rep.cursor_row = cur_row[OUT_ROW_W-1:0];
    rep.cursor_linear = linear[OUT_LIN_W-1:0];
    rep.cell_data = read_cell;
    rep.scrolled = rolled;
  endtask

  task check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (rst) begin
      attr = RESET_ATTRIBUTE;
      blank_cells(0, CELLS);
      cur_col = 0;
      cur_row = 0;
      cursor_reports_q.delete();
    end else begin
      if (text_attribute_we) attr = text_attribute;
      if (m_tvalid && m_tready) begin
        got = res_t'(m_tdata);
        if (cursor_reports_q.size() == 0) begin
          $error("result with no request pending: %h", m_tdata);
          fail_count++;
        end else begin
          want = cursor_reports_q.pop_front();
          check_field("cursor_column", 16'(want.cursor_column), 16'(got.cursor_column));
          check_field("cursor_row", 16'(want.cursor_row), 16'(got.cursor_row));
          check_field("cursor_linear", 16'(want.cursor_linear), 16'(got.cursor_linear));
          check_field("cell_data", want.cell_data, got.cell_data);
          check_field("scrolled", 16'(want.scrolled), 16'(got.scrolled));
        end
      end
      if (s_tvalid && s_tready) begin
        console_apply(s_tuser, s_tdata[7:0], s_tdata[18:8], want);
        cursor_reports_q.push_back(want);
      end
    end
    mismatches <= fail_count;
    outstanding <= cursor_reports_q.size();
  end

endmodule

/* tb/sv/text_console_writer_top_tb.sv */
`timescale 1ns / 1ps

module text_console_writer_top_tb;
  import tcw_pkg::*;

  localparam int COLS = 80;
  localparam int ROWS = 25;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 4;
  // A stray result could trail a full scroll sweep.
  localparam int DRAIN_CYCLES = 2100;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        text_attribute_we;
  logic [7:0]  text_attribute;
  int          mismatches;
  int          outstanding;

  int          commands_sent = 0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;
  bit          hold_off_request = 1'b0;

  text_console_writer_top #(
    .SCREEN_COLUMNS(COLS),
    .SCREEN_ROWS(ROWS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .text_attribute_we(text_attribute_we),
    .text_attribute(text_attribute)
  );

  text_console_writer_checker #(
    .SCREEN_COLUMNS(COLS),
    .SCREEN_ROWS(ROWS)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .text_attribute_we(text_attribute_we),
    .text_attribute(text_attribute),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap(input bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task issue_command(input logic [1:0] op, input logic [7:0] ch, input logic [10:0] addr);
    int gap;
    gap = pick_gap(tx_steady);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {5'd0, addr, ch};
    do @(posedge clk); while (!s_tready);
    commands_sent++;
  endtask

  task settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task set_attribute(input logic [7:0] value);
    settle();
    text_attribute_we <= 1'b1;
    text_attribute <= value;
    @(posedge clk);
    text_attribute_we <= 1'b0;
  endtask

  // Receiver side: random back-pressure, plus one long hold-off on demand.
  initial begin
    int gap;
    m_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = pick_gap(rx_steady);
        if (gap == 0) begin
          m_tready <= 1'b1;
          @(posedge clk);
        end else begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int phase_end;
    int kind;
    int len;
    int n;
    logic [7:0]  ch;
    logic [10:0] addr;
    logic [7:0]  attr_v;

    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_PUT;
    text_attribute_we = 1'b0;
    text_attribute = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // The block blanks its memory after reset before it takes any request.
    do @(posedge clk); while (!s_tready);

    // Reads around the edges of memory, then puts with control bytes.
    issue_command(OP_READ, 8'h00, 11'd0);
    issue_command(OP_READ, 8'h00, 11'd1999);
    issue_command(OP_READ, 8'h00, 11'd2000);
    issue_command(OP_READ, 8'hFF, 11'd2047);
    issue_command(OP_NOP, 8'hFF, 11'd2047);
    issue_command(OP_PUT, 8'h41, 11'd0);
    issue_command(OP_PUT, 8'hFF, 11'd0);
    issue_command(OP_PUT, 8'h00, 11'd0);
    issue_command(OP_PUT, CHAR_RETURN, 11'd0);
    issue_command(OP_READ, 8'h00, 11'd1);
    issue_command(OP_READ, 8'h00, 11'd2);
    issue_command(OP_PUT, 8'h80, 11'd0);
    issue_command(OP_READ, 8'h00, 11'd0);
    issue_command(OP_PUT, CHAR_NEWLINE, 11'd0);
    issue_command(OP_PUT, 8'h55, 11'd0);
    issue_command(OP_READ, 8'h00, 11'd80);
    set_attribute(8'hFF);
    issue_command(OP_PUT, 8'hAA, 11'd0);
    issue_command(OP_READ, 8'h00, 11'd81);
    issue_command(OP_CLEAR, 8'h00, 11'd0);
    issue_command(OP_READ, 8'h00, 11'd1999);
    set_attribute(8'h00);
    issue_command(OP_PUT, 8'h7F, 11'd0);
    issue_command(OP_READ, 8'h00, 11'd0);
    issue_command(OP_READ, 8'h00, 11'd1);

    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: attr_v = 8'h00;
        1: attr_v = 8'hFF;
        2: attr_v = RESET_ATTRIBUTE;
        default: attr_v = 8'($urandom_range(0, 255));
      endcase
      set_attribute(attr_v);
      tx_steady = (phase % 3 == 1);
      rx_steady = (phase % 3 == 1);
      if (phase == 2) hold_off_request = 1'b1;
      phase_end = commands_sent + 100;
      while (commands_sent < phase_end) begin
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
          // A line of text, sometimes long enough to wrap.
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(70, 100) : $urandom_range(1, 40);
          repeat (len) begin
            if ($urandom_range(0, 9) < 7) ch = 8'($urandom_range(8'h20, 8'h7E));
            else ch = 8'($urandom_range(0, 255));
            issue_command(OP_PUT, ch, 11'($urandom_range(0, 2047)));
          end
          n = $urandom_range(0, 9);
          if (n < 7) issue_command(OP_PUT, CHAR_NEWLINE, 11'($urandom_range(0, 2047)));
          else if (n < 8) issue_command(OP_PUT, CHAR_RETURN, 11'($urandom_range(0, 2047)));
        end else if (kind < 60) begin
          len = $urandom_range(1, 6);
          repeat (len) issue_command(OP_PUT, CHAR_NEWLINE, 11'($urandom_range(0, 2047)));
        end else if (kind < 84) begin
          // Reads lean toward the bottom rows, where fresh text lands.
          len = $urandom_range(1, 4);
          repeat (len) begin
            n = $urandom_range(0, 99);
            if (n < 40) addr = 11'($urandom_range(1840, 1999));
            else if (n < 75) addr = 11'($urandom_range(0, 1999));
            else if (n < 85) addr = 11'($urandom_range(2000, 2047));
            else addr = 11'($urandom_range(0, 159));
            issue_command(OP_READ, 8'($urandom_range(0, 255)), addr);
          end
        end else if (kind < 85) begin
          issue_command(OP_CLEAR, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
        end else begin
          // Noise; clears are kept rare so the cursor reaches the bottom row.
          n = $urandom_range(0, 2);
          issue_command((n == 2) ? OP_NOP : 2'(n), 8'($urandom_range(0, 255)),
                        11'($urandom_range(0, 2047)));
        end
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/tcw_pkg.sv
sv/tcw_engine.sv
sv/text_console_writer_top.sv
sv/tcw_checker.sv
tb/sv/text_console_writer_checker.sv
tb/sv/text_console_writer_top_tb.sv
